// ===== rtl/sal_pkg.sv =====
package sal_pkg;

    localparam int unsigned LvlW     = 8;
    localparam int unsigned TickW    = 18;
    localparam int unsigned BlinkW   = 5;
    localparam int unsigned MinW     = 11;
    localparam int unsigned HourW    = 5;
    localparam int unsigned MinuteW  = 6;
    localparam int unsigned PreW     = 7;
    localparam int unsigned PhaseW   = 3;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 7;
    localparam int unsigned SgnW     = 13;
    localparam int unsigned DivSteps = LvlW;
    localparam int unsigned DivCntW  = $clog2(DivSteps);

    localparam logic [LvlW-1:0]     LevelFull   = 8'd255;
    localparam logic [LvlW-1:0]     LevelOff    = 8'd0;
    localparam logic [TickW-1:0]    FullTicks   = 18'd20;
    localparam logic [TickW-1:0]    FinalTicks  = 18'd600;
    localparam logic [TickW-1:0]    TicksPerMin = 18'd120;
    localparam logic [BlinkW-1:0]   BlinkHalves = 5'd20;
    localparam logic [MinW-1:0]     MinPerHour  = 11'd60;
    localparam logic signed [SgnW-1:0] DayMin   = 13'sd1440;
    localparam logic [HourW-1:0]    HourReset   = 5'd0;
    localparam logic [MinuteW-1:0]  MinuteReset = 6'd0;
    localparam logic [PreW-1:0]     PreReset    = 7'd30;

    localparam logic [CfgIdxW-1:0] CFG_ALARM_HOUR   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ALARM_MINUTE = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_PREALARM     = 2'd2;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_ARM  = 1'b1;

    typedef enum logic [PhaseW-1:0] {
        PH_IDLE  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_RAMP  = 3'd2,
        PH_FULL  = 3'd3,
        PH_BLINK = 3'd4,
        PH_FINAL = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EXEC,
        ST_PUSH
    } t_ctl_state;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_step;
        logic exec;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic arm_go;
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/sal_in_if.sv =====
interface sal_in_if import sal_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [MinW-1:0]   minute_of_day;

    modport source(output valid, kind, minute_of_day, input ready);
    modport sink(input valid, kind, minute_of_day, output ready);
endinterface

// ===== rtl/sal_out_if.sv =====
interface sal_out_if import sal_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LvlW-1:0]   brightness;
    logic [PhaseW-1:0] phase;
    logic              alarm_active;

    modport source(output valid, brightness, phase, alarm_active, input ready);
    modport sink(input valid, brightness, phase, alarm_active, output ready);
endinterface

// ===== rtl/sunrise_alarm_led_sequencer.sv =====
// Channel   Direction  Payload
// i_in      sink       kind, minute_of_day
// o_out     source     brightness, phase, alarm_active
// i_cfg_*   write      i_cfg_idx selects alarm_hour, alarm_minute or prealarm_minutes
//
// A tick beat passes the controller from ST_IDLE, where it is accepted, through ST_EXEC to ST_PUSH.
// An arm beat in the idle phase also steps through ST_DIV for the 8-step divider before ST_EXEC.
// The result beat enters the output register when the controller leaves ST_PUSH.
// An output register holds the result, so a new beat is accepted while it waits.
// A stall on o_out holds the controller before loading the next result.
// Reset is synchronous and active low and restores the register defaults.
module sunrise_alarm_led_sequencer import sal_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sal_in_if.sink              i_in,
    sal_out_if.source           o_out,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    sal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sal_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_kind          (i_in.kind),
        .i_minute_of_day (i_in.minute_of_day),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_brightness    (o_out.brightness),
        .o_phase         (o_out.phase),
        .o_alarm_active  (o_out.alarm_active)
    );

endmodule

// ===== rtl/sal_ctrl.sv =====
module sal_ctrl import sal_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_sts.arm_go) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIV;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sal_dp.sv =====
module sal_dp import sal_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_kind,
    input  logic [MinW-1:0]     i_minute_of_day,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [LvlW-1:0]     o_brightness,
    output logic [PhaseW-1:0]   o_phase,
    output logic                o_alarm_active
);

    logic [HourW-1:0]   r_hour;
    logic [MinuteW-1:0] r_minute;
    logic [PreW-1:0]    r_pre;

    t_phase             r_phase;
    logic [TickW-1:0]   r_tick;
    logic [LvlW-1:0]    r_level;
    logic [LvlW-1:0]    r_step;
    logic [BlinkW-1:0]  r_blink;
    logic               r_armed;

    logic               r_kind;
    logic [MinW-1:0]    r_wait;
    logic [PreW-1:0]    r_den;
    logic [LvlW-1:0]    r_rem;
    logic [LvlW-1:0]    r_quo;
    logic [DivCntW-1:0] r_cnt;

    logic               r_out_valid;
    logic [LvlW-1:0]    r_out_level;
    logic [PhaseW-1:0]  r_out_phase;
    logic               r_out_armed;

    t_phase             n_phase;
    logic [TickW-1:0]   n_tick;
    logic [LvlW-1:0]    n_level;
    logic [LvlW-1:0]    n_step;
    logic [BlinkW-1:0]  n_blink;
    logic               n_armed;

    logic [PreW-1:0]        pre_eff;
    logic [MinW-1:0]        alarm_min;
    logic signed [SgnW-1:0] start_s;
    logic signed [SgnW-1:0] cur_s;
    logic signed [SgnW-1:0] diff_s;
    logic signed [SgnW-1:0] wait_s;
    logic [MinW-1:0]        n_wait;
    logic [LvlW-1:0]        trial;
    logic                   fits;
    logic                   tick_done;
    logic [TickW-1:0]       tick_dec;
    logic [LvlW:0]          ramp_sum;
    logic [TickW-1:0]       wait_ticks;

    // A prealarm of zero behaves as one minute.
    assign pre_eff   = (r_pre == '0) ? PreW'(1) : r_pre;
    assign alarm_min = MinW'(r_hour) * MinPerHour + MinW'(r_minute);
    assign start_s   = $signed({2'b00, alarm_min}) - $signed({6'b000000, pre_eff});
    assign cur_s     = $signed({2'b00, i_minute_of_day});
    assign diff_s    = start_s - cur_s;
    assign wait_s    = (cur_s >= start_s) ? diff_s + DayMin : diff_s;
    assign n_wait    = wait_s[SgnW-1] ? '0 : wait_s[MinW-1:0];

    assign trial = {r_rem[LvlW-2:0], r_quo[LvlW-1]};
    assign fits  = trial >= {1'b0, r_den};

    // Minutes times 120 ticks, as 128x minus 8x.
    assign wait_ticks = {r_wait, 7'b0000000} - {4'b0000, r_wait, 3'b000};

    assign tick_done = r_tick <= TickW'(1);
    assign tick_dec  = r_tick - TickW'(1);
    assign ramp_sum  = {1'b0, r_level} + {1'b0, r_step};

    assign o_sts.arm_go   = (i_kind == KIND_ARM) && (r_phase == PH_IDLE);
    assign o_sts.div_last = r_cnt == DivCntW'(DivSteps - 1);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_level = r_level;
        n_step  = r_step;
        n_blink = r_blink;
        n_armed = r_armed;
        if (r_kind == KIND_ARM) begin
            if (r_phase == PH_IDLE) begin
                n_step  = r_quo;
                n_armed = 1'b1;
                n_phase = PH_WAIT;
                n_tick  = wait_ticks;
            end
        end else begin
            case (r_phase)
                PH_WAIT: begin
                    n_tick = tick_done ? '0 : tick_dec;
                    if (tick_done) begin
                        if (r_step != LevelFull) begin
                            n_level = r_step;
                            n_phase = PH_RAMP;
                            n_tick  = TicksPerMin;
                        end else begin
                            n_level = LevelFull;
                            n_phase = PH_FULL;
                            n_tick  = FullTicks;
                        end
                    end
                end
                PH_RAMP: begin
                    n_tick = tick_done ? '0 : tick_dec;
                    if (tick_done) begin
                        if (ramp_sum < {1'b0, LevelFull}) begin
                            n_level = ramp_sum[LvlW-1:0];
                            n_tick  = TicksPerMin;
                        end else begin
                            n_level = LevelFull;
                            n_phase = PH_FULL;
                            n_tick  = FullTicks;
                        end
                    end
                end
                PH_FULL: begin
                    n_tick = tick_done ? '0 : tick_dec;
                    if (tick_done) begin
                        n_level = LevelOff;
                        n_phase = PH_BLINK;
                        n_blink = BlinkW'(1);
                    end
                end
                PH_BLINK: begin
                    if (r_blink < BlinkHalves) begin
                        n_level = r_blink[0] ? LevelFull : LevelOff;
                        n_blink = r_blink + BlinkW'(1);
                    end else begin
                        n_level = LevelFull;
                        n_phase = PH_FINAL;
                        n_tick  = FinalTicks;
                    end
                end
                PH_FINAL: begin
                    n_tick = tick_done ? '0 : tick_dec;
                    if (tick_done) begin
                        n_level = LevelOff;
                        n_phase = PH_IDLE;
                        n_armed = 1'b0;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour   <= HourReset;
            r_minute <= MinuteReset;
            r_pre    <= PreReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALARM_HOUR:   r_hour   <= i_cfg_data[HourW-1:0];
                CFG_ALARM_MINUTE: r_minute <= i_cfg_data[MinuteW-1:0];
                CFG_PREALARM:     r_pre    <= i_cfg_data[PreW-1:0];
                default:          r_pre    <= r_pre;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_level <= '0;
            r_step  <= '0;
            r_blink <= '0;
            r_armed <= 1'b0;
        end else if (i_cmd.exec) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_level <= n_level;
            r_step  <= n_step;
            r_blink <= n_blink;
            r_armed <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + DivCntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind <= i_kind;
        end
        if (i_cmd.div_start) begin
            r_wait <= n_wait;
            r_den  <= pre_eff;
            r_rem  <= '0;
            r_quo  <= LevelFull;
        end else if (i_cmd.div_step) begin
            r_rem <= fits ? trial - {1'b0, r_den} : trial;
            r_quo <= {r_quo[LvlW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_level <= r_level;
            r_out_phase <= r_phase;
            r_out_armed <= r_armed;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_brightness   = r_out_level;
    assign o_phase        = r_out_phase;
    assign o_alarm_active = r_out_armed;

endmodule

// ===== sim/sunrise_alarm_led_sequencer_checker.sv =====
module sunrise_alarm_led_sequencer_checker import sal_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sal_in_if                   i_in,
    sal_out_if                  i_out,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output int                  o_fail_count
);

    typedef struct packed {
        logic [LvlW-1:0] level;
        t_phase          phase;
        logic            active;
    } t_lamp;

    logic [HourW-1:0]   alarm_hour;
    logic [MinuteW-1:0] alarm_minute;
    logic [PreW-1:0]    prealarm;

    t_phase             phase_now;
    logic [TickW-1:0]   ticks_left;
    logic [LvlW-1:0]    glow;
    logic [LvlW-1:0]    glow_step;
    logic [BlinkW-1:0]  halves;
    logic               armed;

    t_lamp lamp_due[$];
    int    mismatches;
    int    beats_seen;

    function automatic bit timer_done();
        if (ticks_left > 1) begin
            ticks_left = ticks_left - 1'b1;
            return 1'b0;
        end
        ticks_left = '0;
        return 1'b1;
    endfunction

    function automatic void light_full();
        glow = LevelFull;
        phase_now = PH_FULL;
        ticks_left = FullTicks;
    endfunction

    function automatic t_lamp lamp_after(input logic kind, input logic [MinW-1:0] minute);
        int p;
        int start;
        int wait_min;
        logic [LvlW:0] next_glow;
        if (kind == KIND_ARM) begin
            if (phase_now == PH_IDLE) begin
                p = (prealarm == '0) ? 1 : int'(prealarm);
                start = int'(alarm_hour) * int'(MinPerHour) + int'(alarm_minute) - p;
                if (int'(minute) >= start) begin
                    wait_min = int'(DayMin) - int'(minute) + start;
                end else begin
                    wait_min = start - int'(minute);
                end
                if (wait_min < 0) begin
                    wait_min = 0;
                end
                glow_step = LvlW'(int'(LevelFull) / p);
                armed = 1'b1;
                phase_now = PH_WAIT;
                ticks_left = TickW'(wait_min * int'(TicksPerMin));
            end
        end else begin
            case (phase_now)
                PH_WAIT: begin
                    if (timer_done()) begin
                        if (glow_step < LevelFull) begin
                            glow = glow_step;
                            phase_now = PH_RAMP;
                            ticks_left = TicksPerMin;
                        end else begin
                            light_full();
                        end
                    end
                end
                PH_RAMP: begin
                    if (timer_done()) begin
                        next_glow = {1'b0, glow} + {1'b0, glow_step};
                        if (next_glow < {1'b0, LevelFull}) begin
                            glow = next_glow[LvlW-1:0];
                            ticks_left = TicksPerMin;
                        end else begin
                            light_full();
                        end
                    end
                end
                PH_FULL: begin
                    if (timer_done()) begin
                        glow = LevelOff;
                        phase_now = PH_BLINK;
                        halves = BlinkW'(1);
                    end
                end
                PH_BLINK: begin
                    if (halves < BlinkHalves) begin
                        glow = halves[0] ? LevelFull : LevelOff;
                        halves = halves + 1'b1;
                    end else begin
                        glow = LevelFull;
                        phase_now = PH_FINAL;
                        ticks_left = FinalTicks;
                    end
                end
                PH_FINAL: begin
                    if (timer_done()) begin
                        glow = LevelOff;
                        phase_now = PH_IDLE;
                        armed = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        return '{level: glow, phase: phase_now, active: armed};
    endfunction

    always @(posedge i_clk) begin
        t_lamp seen;
        t_lamp want;
        if (!i_rst_n) begin
            alarm_hour = HourReset;
            alarm_minute = MinuteReset;
            prealarm = PreReset;
            phase_now = PH_IDLE;
            ticks_left = '0;
            glow = LevelOff;
            glow_step = '0;
            halves = '0;
            armed = 1'b0;
            lamp_due.delete();
            mismatches = 0;
            beats_seen = 0;
        end else begin
            // The result leaves before the new beat is predicted, so a beat that
            // arrives on the same edge can never answer for itself.
            if (i_out.valid && i_out.ready) begin
                beats_seen++;
                seen = '{level: i_out.brightness, phase: t_phase'(i_out.phase),
                         active: i_out.alarm_active};
                if (lamp_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result beat %0d arrived with nothing pending:",
                                 beats_seen);
                        $display("  brightness %0d, phase %0d, alarm_active %0b",
                                 seen.level, seen.phase, seen.active);
                    end
                end else begin
                    want = lamp_due.pop_front();
                    if (seen.level !== want.level || seen.phase !== want.phase
                            || seen.active !== want.active) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Result beat %0d mismatch (actual / expected):",
                                     beats_seen);
                            $display("  level %0d / %0d, phase %0d / %0d, active %0b / %0b",
                                     seen.level, want.level, seen.phase, want.phase,
                                     seen.active, want.active);
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                lamp_due.push_back(lamp_after(i_in.kind, i_in.minute_of_day));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ALARM_HOUR:   alarm_hour = i_cfg_data[HourW-1:0];
                    CFG_ALARM_MINUTE: alarm_minute = i_cfg_data[MinuteW-1:0];
                    CFG_PREALARM:     prealarm = i_cfg_data[PreW-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches + int'(lamp_due.size());
    end

endmodule

// ===== sim/sunrise_alarm_led_sequencer_tb.sv =====
module sunrise_alarm_led_sequencer_tb;
    import sal_pkg::*;

    localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
    localparam int ItemTarget = 1500;
    localparam int CycleLimit = 1000000;
    localparam int HoldCycles = 300;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_data;
    int                  fail_count;

    bit     tx_idle;
    bit     rx_idle;
    int     rx_hold;
    int     sent;
    int     got;
    int     arm_beats;
    int     reg_writes;
    int     finished;
    int     cycles;
    t_phase last_phase = PH_IDLE;

    sal_in_if  in_ch();
    sal_out_if out_ch();

    sunrise_alarm_led_sequencer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    sunrise_alarm_led_sequencer_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("Run stopped after %0d cycles with %0d of %0d results back.",
                     cycles, got, sent);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_beat(input logic kind, input logic [MinW-1:0] minute);
        int w;
        w = tx_idle ? int'($urandom_range(18, 0)) : 0;
        if (w > 0) begin
            in_ch.valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.minute_of_day <= minute;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sent++;
        if (kind == KIND_ARM) begin
            arm_beats++;
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (got != sent) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    initial begin : rx
        int w;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                w = rx_hold;
                rx_hold = 0;
            end else begin
                w = rx_idle ? int'($urandom_range(18, 0)) : 0;
            end
            if (w > 0) begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            if (last_phase == PH_FINAL && out_ch.phase == PH_IDLE) begin
                finished++;
            end
            last_phase = t_phase'(out_ch.phase);
            got++;
        end
    end

    initial begin : stim
        int  hr;
        int  mn;
        int  pre;
        int  start;
        int  cur;
        int  n;
        int  work;
        bit  held;
        in_ch.valid <= 1'b0;
        in_ch.kind <= KIND_TICK;
        in_ch.minute_of_day <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_ALARM_HOUR;
        cfg_data <= '0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_beat(KIND_TICK, '1);
        send_beat(KIND_TICK, '0);
        drain();
        write_reg(CFG_SPARE, '1);
        write_reg(CFG_ALARM_HOUR, CfgDataW'(0));
        write_reg(CFG_ALARM_MINUTE, CfgDataW'(2));
        write_reg(CFG_PREALARM, '0);
        // The ramp would start at minute 1, so arming at the last encodable minute
        // leaves a negative wait, and a ramp length of zero skips the ramp entirely.
        send_beat(KIND_ARM, '1);
        send_beat(KIND_ARM, '0);
        send_beat(KIND_TICK, MinW'(1234));
        drain();
        write_reg(CFG_PREALARM, CfgDataW'(127));
        write_reg(CFG_ALARM_HOUR, CfgDataW'(23));
        repeat (20) send_beat(KIND_TICK, MinW'($urandom_range(2047, 0)));

        while (work < ItemTarget) begin
            tx_idle = $urandom_range(2, 0) != 0;
            rx_idle = $urandom_range(2, 0) != 0;
            drain();
            if (last_phase == PH_IDLE) begin
                hr = ($urandom_range(3, 0) == 0) ? 0 : int'($urandom_range(23, 0));
                mn = $urandom_range(63, 0);
                case ($urandom_range(9, 0))
                    0:       pre = 0;
                    1, 2:    pre = 1;
                    3, 4:    pre = 2;
                    5, 6:    pre = 3;
                    7:       pre = 4;
                    default: pre = $urandom_range(8, 5);
                endcase
                write_reg(CFG_ALARM_HOUR, CfgDataW'(hr));
                write_reg(CFG_ALARM_MINUTE, CfgDataW'(mn));
                write_reg(CFG_PREALARM, CfgDataW'(pre));
                // Arm a minute or two ahead of the ramp, or late enough that the wait clamps.
                start = hr * 60 + mn - ((pre == 0) ? 1 : pre);
                if (start >= 2 && (start > 606 || $urandom_range(2, 0) != 0)) begin
                    cur = start - int'($urandom_range(2, 1));
                end else begin
                    cur = $urandom_range(2047, 1441 + start);
                end
                send_beat(KIND_ARM, MinW'(cur));
                work++;
            end
            n = $urandom_range(80, 20);
            if (!held && work > 400) begin
                held = 1'b1;
                rx_hold = HoldCycles;
                n = 80;
            end
            repeat (n) begin
                if ($urandom_range(24, 0) == 0 && last_phase != PH_FINAL
                        && last_phase != PH_IDLE) begin
                    send_beat(KIND_ARM, MinW'($urandom_range(2047, 0)));
                end else begin
                    if (last_phase != PH_IDLE) begin
                        work++;
                    end
                    send_beat(KIND_TICK, MinW'($urandom_range(2047, 0)));
                end
            end
        end

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        drain();
        while (last_phase != PH_IDLE) begin
            repeat (16) send_beat(KIND_TICK, '0);
            drain();
        end
        write_reg(CFG_ALARM_HOUR, '1);
        write_reg(CFG_ALARM_MINUTE, '1);
        write_reg(CFG_PREALARM, '1);
        // Arming at exactly the ramp start means the ramp is a whole day away.
        send_beat(KIND_ARM, MinW'(1796));
        repeat (8) send_beat(KIND_TICK, '1);
        drain();
        write_reg(CFG_PREALARM, CfgDataW'(1));
        send_beat(KIND_ARM, MinW'(100));
        repeat (8) send_beat(KIND_TICK, '0);
        drain();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d beats with %0d arm requests and %0d register writes.",
                 sent, arm_beats, reg_writes);
        $display("%0d alarms ran from arming through ramp, blinking and final hold to dark.",
                 finished);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sal_pkg.sv
rtl/sal_in_if.sv
rtl/sal_out_if.sv
rtl/sal_ctrl.sv
rtl/sal_dp.sv
rtl/sunrise_alarm_led_sequencer.sv
sim/sunrise_alarm_led_sequencer_checker.sv
sim/sunrise_alarm_led_sequencer_tb.sv
